@@ design/bmp24_pkg.sv @@
// shared constants, status codes and result word type for the bmp24 stream decoder
`default_nettype none
package bmp24_pkg;

  // default size limits
  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;

  // header layout, byte offsets from the start of the file
  localparam int unsigned HDR_LEN    = 54;
  localparam int unsigned SIG_OFS    = 0;
  localparam int unsigned WIDTH_OFS  = 18;
  localparam int unsigned HEIGHT_OFS = 22;
  localparam int unsigned DEPTH_OFS  = 28;
  localparam int unsigned COMP_OFS   = 30;

  // expected header values
  localparam logic [15:0] SIG_VALUE = 16'h4D42;
  localparam logic [15:0] DEPTH_24  = 16'd24;

  // result status codes
  typedef enum logic [2:0] {
    ST_HEADER_OK = 3'd0,
    ST_PIXEL     = 3'd1,
    ST_BAD_SIG   = 3'd2,
    ST_BAD_COMP  = 3'd3,
    ST_BAD_DEPTH = 3'd4,
    ST_TOO_LARGE = 3'd5
  } status_t;

  // one result word
  typedef struct packed {
    status_t     status;
    logic        last;
    logic [12:0] height;
    logic [12:0] width;
    logic [11:0] row;
    logic [11:0] col;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
  } out_word_t;

endpackage
`default_nettype wire

@@ design/bmp24_stream_decoder.sv @@
// 24-bit uncompressed bmp byte stream decoder: header parse and pixel assembly
// results are registered: each result goes to the output register, or to the skid register while it is stalled
// throughput: one byte per cycle; the header, pixel and padding counters update in
// the same cycle the byte is taken, and a skid register holds one result while the
// output is stalled, so input stops only when both output registers are full
// reset: synchronous active-low rst_n returns the parser to header byte 0 and empties
// the output registers
`default_nettype none
module bmp24_stream_decoder #(
  parameter int MAX_WIDTH  = bmp24_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bmp24_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // data_byte
  input  wire logic [0:0]  in_tuser,   // start_of_file
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [79:0]      out_tdata,  // red, green, blue, column, row, image_width,
                                       // image_height, zero fill
  output logic [2:0]       out_tuser,  // status
  output logic             out_tlast   // last_pixel
);

  localparam int CW = ($clog2(MAX_WIDTH) > 12) ? $clog2(MAX_WIDTH) : 12;
  localparam int RW = ($clog2(MAX_HEIGHT) > 12) ? $clog2(MAX_HEIGHT) : 12;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PIXELS,
    PH_PAD,
    PH_IDLE
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [5:0]          hidx_r, hidx_nxt;
  logic [15:0]         sig_r, sig_nxt;
  logic [31:0]         width_r, width_nxt;
  logic [31:0]         height_r, height_nxt;
  logic [15:0]         depth_r, depth_nxt;
  logic [31:0]         comp_r, comp_nxt;
  logic [CW-1:0]       col_r, col_nxt;
  logic [RW-1:0]       row_r, row_nxt;
  logic [1:0]          bip_r, bip_nxt;
  logic [1:0]          pad_r, pad_nxt;
  logic [7:0]          blue_r, blue_nxt;
  logic [7:0]          green_r, green_nxt;
  logic                ov_r, ov_nxt;
  logic                sv_r, sv_nxt;
  bmp24_pkg::out_word_t ow_r, ow_nxt;
  bmp24_pkg::out_word_t sw_r, sw_nxt;

  logic                 accept;
  logic                 push;
  bmp24_pkg::out_word_t res;
  logic [31:0]          w_size;
  logic [31:0]          h_size;

  assign accept = in_tvalid && in_tready;
  assign in_tready = !sv_r;

  // header sizes, negative reads as zero
  assign w_size = width_r[31] ? 32'd0 : width_r;
  assign h_size = height_r[31] ? 32'd0 : height_r;

  // parser next state and result for the byte on the input
  always_comb begin
    phase_t     ph;
    logic [5:0] idx;
    logic [5:0] lane;
    logic       col_end;
    logic       row_end;
    ph         = in_tuser[0] ? PH_HEADER : phase_r;
    idx        = in_tuser[0] ? 6'd0 : hidx_r;
    lane       = 6'd0;
    col_end    = (32'(col_r) + 32'd1) >= w_size;
    row_end    = (32'(row_r) + 32'd1) >= h_size;
    phase_nxt  = phase_r;
    hidx_nxt   = hidx_r;
    sig_nxt    = sig_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    depth_nxt  = depth_r;
    comp_nxt   = comp_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    bip_nxt    = bip_r;
    pad_nxt    = pad_r;
    blue_nxt   = blue_r;
    green_nxt  = green_r;
    push       = 1'b0;
    res        = '0;
    res.width  = w_size[12:0];
    res.height = h_size[12:0];

    if (accept) begin
      if (in_tuser[0]) begin
        phase_nxt = PH_HEADER;
        hidx_nxt  = 6'd0;
        col_nxt   = '0;
        row_nxt   = '0;
        bip_nxt   = 2'd0;
        pad_nxt   = 2'd0;
      end
      case (ph)
        PH_HEADER: begin
          // capture little-endian header fields
          if (32'(idx) < bmp24_pkg::SIG_OFS + 2) begin
            lane = idx - 6'(bmp24_pkg::SIG_OFS);
            if (lane[0]) sig_nxt[15:8] = in_tdata;
            else sig_nxt[7:0] = in_tdata;
          end else if (32'(idx) >= bmp24_pkg::WIDTH_OFS &&
                       32'(idx) < bmp24_pkg::WIDTH_OFS + 4) begin
            lane = idx - 6'(bmp24_pkg::WIDTH_OFS);
            width_nxt[lane[1:0]*8 +: 8] = in_tdata;
          end else if (32'(idx) >= bmp24_pkg::HEIGHT_OFS &&
                       32'(idx) < bmp24_pkg::HEIGHT_OFS + 4) begin
            lane = idx - 6'(bmp24_pkg::HEIGHT_OFS);
            height_nxt[lane[1:0]*8 +: 8] = in_tdata;
          end else if (32'(idx) >= bmp24_pkg::DEPTH_OFS &&
                       32'(idx) < bmp24_pkg::DEPTH_OFS + 2) begin
            lane = idx - 6'(bmp24_pkg::DEPTH_OFS);
            if (lane[0]) depth_nxt[15:8] = in_tdata;
            else depth_nxt[7:0] = in_tdata;
          end else if (32'(idx) >= bmp24_pkg::COMP_OFS &&
                       32'(idx) < bmp24_pkg::COMP_OFS + 4) begin
            lane = idx - 6'(bmp24_pkg::COMP_OFS);
            comp_nxt[lane[1:0]*8 +: 8] = in_tdata;
          end

          if (32'(idx) + 1 < bmp24_pkg::HDR_LEN) begin
            hidx_nxt = idx + 6'd1;
          end else begin
            // last header byte: report status
            hidx_nxt = 6'd0;
            push     = 1'b1;
            if (sig_r != bmp24_pkg::SIG_VALUE) begin
              res.status = bmp24_pkg::ST_BAD_SIG;
            end else if (comp_r != 32'd0) begin
              res.status = bmp24_pkg::ST_BAD_COMP;
            end else if (depth_r != bmp24_pkg::DEPTH_24) begin
              res.status = bmp24_pkg::ST_BAD_DEPTH;
            end else if (w_size > 32'(MAX_WIDTH) || h_size > 32'(MAX_HEIGHT)) begin
              res.status = bmp24_pkg::ST_TOO_LARGE;
            end else begin
              res.status = bmp24_pkg::ST_HEADER_OK;
            end
            if (res.status != bmp24_pkg::ST_HEADER_OK) begin
              phase_nxt = PH_IDLE;
            end else if (w_size == 32'd0 || h_size == 32'd0) begin
              res.last  = 1'b1;
              phase_nxt = PH_IDLE;
            end else begin
              phase_nxt = PH_PIXELS;
              col_nxt   = '0;
              row_nxt   = '0;
              bip_nxt   = 2'd0;
              pad_nxt   = 2'd0;
            end
          end
        end
        PH_PAD: begin
          // skip row padding
          if (pad_r > 2'd1) begin
            pad_nxt = pad_r - 2'd1;
          end else begin
            pad_nxt   = 2'd0;
            phase_nxt = PH_PIXELS;
          end
        end
        PH_PIXELS: begin
          // assemble blue, green, red into one pixel
          if (bip_r == 2'd0) begin
            blue_nxt = in_tdata;
            bip_nxt  = 2'd1;
          end else if (bip_r == 2'd1) begin
            green_nxt = in_tdata;
            bip_nxt   = 2'd2;
          end else begin
            bip_nxt    = 2'd0;
            push       = 1'b1;
            res.status = bmp24_pkg::ST_PIXEL;
            res.red    = in_tdata;
            res.green  = green_r;
            res.blue   = blue_r;
            res.col    = col_r[11:0];
            res.row    = row_r[11:0];
            if (col_end) begin
              col_nxt = '0;
              if (row_end) begin
                res.last  = 1'b1;
                phase_nxt = PH_IDLE;
              end else begin
                row_nxt = row_r + RW'(1);
                pad_nxt = w_size[1:0];
                if (w_size[1:0] != 2'd0) phase_nxt = PH_PAD;
              end
            end else begin
              col_nxt = col_r + CW'(1);
            end
          end
        end
        default: begin
          // idle until the next start of file
        end
      endcase
    end
  end

  // output register with skid stage
  always_comb begin
    ov_nxt = ov_r;
    sv_nxt = sv_r;
    ow_nxt = ow_r;
    sw_nxt = sw_r;
    if (!ov_r || out_tready) begin
      if (sv_r) begin
        ow_nxt = sw_r;
        ov_nxt = 1'b1;
        sv_nxt = 1'b0;
      end else begin
        ow_nxt = res;
        ov_nxt = push;
      end
    end else if (push) begin
      sw_nxt = res;
      sv_nxt = 1'b1;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      hidx_r  <= 6'd0;
      col_r   <= '0;
      row_r   <= '0;
      bip_r   <= 2'd0;
      pad_r   <= 2'd0;
      ov_r    <= 1'b0;
      sv_r    <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      hidx_r  <= hidx_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      bip_r   <= bip_nxt;
      pad_r   <= pad_nxt;
      ov_r    <= ov_nxt;
      sv_r    <= sv_nxt;
    end
    sig_r    <= sig_nxt;
    width_r  <= width_nxt;
    height_r <= height_nxt;
    depth_r  <= depth_nxt;
    comp_r   <= comp_nxt;
    blue_r   <= blue_nxt;
    green_r  <= green_nxt;
    ow_r     <= ow_nxt;
    sw_r     <= sw_nxt;
  end

  // output word packing
  assign out_tvalid = ov_r;
  assign out_tuser  = ow_r.status;
  assign out_tlast  = ow_r.last;
  assign out_tdata  = {6'd0, ow_r.height, ow_r.width, ow_r.row, ow_r.col,
                       ow_r.blue, ow_r.green, ow_r.red};

endmodule
`default_nettype wire
